>>> sv/q24a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q24a_pkg
// Shared widths, operation codes and the pipeline stage record of the
// Q24.8 fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package q24a_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 8;
    localparam int NUM_W      = DATA_WIDTH + FRAC_BITS;
    localparam int DIV_STEPS  = NUM_W;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int IN_W       = 4 + 2 * DATA_WIDTH;
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W      = DATA_WIDTH + 5;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic                  lt;
        logic                  eq;
        logic                  gt;
        logic [DATA_WIDTH-1:0] res;
        logic                  ovf;
        logic                  dz;
        logic                  neg;
        logic [DATA_WIDTH-1:0] mag_a;
        logic [DATA_WIDTH-1:0] mag_b;
        logic [PROD_W-1:0]     prod;
        logic [NUM_W-1:0]      num;
        logic [DATA_WIDTH-1:0] rem;
    } t_stage;

    function automatic logic [DATA_WIDTH:0] sat_wide(input logic [DATA_WIDTH:0] s);
        logic [DATA_WIDTH:0] r;
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            r = {1'b1, s[DATA_WIDTH] ? MINV : MAXV};
        end else begin
            r = {1'b0, s[DATA_WIDTH-1:0]};
        end
        return r;
    endfunction

endpackage

>>> sv/q24a_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q24a_front
// Input stage: operand magnitudes, compare flags and the results of the
// operations that need neither the multiplier nor the divide steps, all registered.
// ----------------------------------------------------------------------------
module q24a_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [3:0]                          i_op,
    input  logic [q24a_pkg::DATA_WIDTH-1:0]     i_a,
    input  logic [q24a_pkg::DATA_WIDTH-1:0]     i_b,
    output logic                                o_valid,
    output q24a_pkg::t_stage                    o_stage
);
    import q24a_pkg::*;

    logic                  r_valid;
    t_stage                r_stage;
    t_stage                n_stage;
    logic [DATA_WIDTH:0]   sum_w;
    logic [DATA_WIDTH:0]   dif_w;
    logic [DATA_WIDTH:0]   sum_s;
    logic [DATA_WIDTH:0]   dif_s;
    logic [FRAC_BITS:0]    top_a;

    always_comb begin
        sum_w = {i_a[DATA_WIDTH-1], i_a} + {i_b[DATA_WIDTH-1], i_b};
        dif_w = {i_a[DATA_WIDTH-1], i_a} - {i_b[DATA_WIDTH-1], i_b};
        sum_s = sat_wide(sum_w);
        dif_s = sat_wide(dif_w);
        top_a = i_a[DATA_WIDTH-1:DATA_WIDTH-1-FRAC_BITS];

        n_stage       = '0;
        n_stage.op    = t_op'(i_op);
        n_stage.lt    = $signed(i_a) < $signed(i_b);
        n_stage.eq    = i_a == i_b;
        n_stage.gt    = $signed(i_a) > $signed(i_b);
        n_stage.neg   = i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
        n_stage.mag_a = i_a[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - i_a) : i_a;
        n_stage.mag_b = i_b[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - i_b) : i_b;
        n_stage.num   = {n_stage.mag_a, {FRAC_BITS{1'b0}}};

        unique case (i_op)
            OP_ADD: begin
                n_stage.res = sum_s[DATA_WIDTH-1:0];
                n_stage.ovf = sum_s[DATA_WIDTH];
            end
            OP_SUB: begin
                n_stage.res = dif_s[DATA_WIDTH-1:0];
                n_stage.ovf = dif_s[DATA_WIDTH];
            end
            OP_DIV: begin
                if (i_b == '0) begin
                    n_stage.dz  = 1'b1;
                    n_stage.res = i_a[DATA_WIDTH-1] ? MINV : MAXV;
                end
            end
            OP_MIN: n_stage.res = n_stage.lt ? i_a : i_b;
            OP_MAX: n_stage.res = n_stage.gt ? i_a : i_b;
            OP_INC: begin
                n_stage.ovf = i_a == MAXV;
                n_stage.res = n_stage.ovf ? MAXV : i_a + DATA_WIDTH'(1);
            end
            OP_DEC: begin
                n_stage.ovf = i_a == MINV;
                n_stage.res = n_stage.ovf ? MINV : i_a - DATA_WIDTH'(1);
            end
            OP_FROM_INT: begin
                n_stage.ovf = !((top_a == '0) || (top_a == '1));
                if (n_stage.ovf) begin
                    n_stage.res = i_a[DATA_WIDTH-1] ? MINV : MAXV;
                end else begin
                    n_stage.res = i_a << FRAC_BITS;
                end
            end
            OP_TO_INT: n_stage.res = DATA_WIDTH'($signed(i_a) >>> FRAC_BITS);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> sv/q24a_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q24a_mul
// Magnitude product stage: one unsigned 32x32 multiply, registered.
// ----------------------------------------------------------------------------
module q24a_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  q24a_pkg::t_stage i_stage,
    output logic             o_valid,
    output q24a_pkg::t_stage o_stage
);
    import q24a_pkg::*;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    always_comb begin
        n_stage      = i_stage;
        n_stage.prod = PROD_W'(i_stage.mag_a) * PROD_W'(i_stage.mag_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> sv/q24a_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q24a_div_step
// One restoring division step: shift in a numerator bit, trial subtract,
// shift the quotient bit in, registered.
// ----------------------------------------------------------------------------
module q24a_div_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  q24a_pkg::t_stage i_stage,
    output logic             o_valid,
    output q24a_pkg::t_stage o_stage
);
    import q24a_pkg::*;

    logic                r_valid;
    t_stage              r_stage;
    t_stage              n_stage;
    logic [DATA_WIDTH:0] trial;
    logic                ge;

    always_comb begin
        trial       = {i_stage.rem, i_stage.num[NUM_W-1]};
        ge          = trial >= {1'b0, i_stage.mag_b};
        n_stage     = i_stage;
        n_stage.rem = ge ? DATA_WIDTH'(trial - {1'b0, i_stage.mag_b})
                         : trial[DATA_WIDTH-1:0];
        n_stage.num = {i_stage.num[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> sv/q24a_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q24a_back
// Output stage: round half away from zero, saturate, pick the result and
// hold it in the output register.
// ----------------------------------------------------------------------------
module q24a_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  q24a_pkg::t_stage                     i_stage,
    output logic                                 o_valid,
    output logic [q24a_pkg::OUT_BYTES_W-1:0]     o_data
);
    import q24a_pkg::*;

    logic                   r_valid;
    logic [OUT_W-1:0]       r_data;
    logic [OUT_W-1:0]       n_data;
    logic [PROD_W-1:0]      mul_q;
    logic [PROD_W-1:0]      div_q;
    logic [PROD_W-1:0]      q;
    logic [PROD_W-1:0]      lim;
    logic                   rnd;
    logic                   use_q;
    logic                   q_ovf;
    logic [DATA_WIDTH-1:0]  q_res;
    logic [DATA_WIDTH-1:0]  res;
    logic                   ovf;

    always_comb begin
        mul_q = (i_stage.prod + PROD_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        rnd   = {i_stage.rem, 1'b0} >= {1'b0, i_stage.mag_b};
        div_q = PROD_W'(i_stage.num) + PROD_W'(rnd);
        q     = (i_stage.op == OP_MUL) ? mul_q : div_q;
        lim   = PROD_W'(MAXV) + PROD_W'(i_stage.neg);
        q_ovf = q > lim;
        if (q_ovf) begin
            q_res = i_stage.neg ? MINV : MAXV;
        end else if (i_stage.neg) begin
            q_res = DATA_WIDTH'(0) - q[DATA_WIDTH-1:0];
        end else begin
            q_res = q[DATA_WIDTH-1:0];
        end
        use_q = (i_stage.op == OP_MUL) || ((i_stage.op == OP_DIV) && !i_stage.dz);
        res   = use_q ? q_res : i_stage.res;
        ovf   = use_q ? q_ovf : i_stage.ovf;
        n_data = {i_stage.dz, ovf, i_stage.gt, i_stage.eq, i_stage.lt, res};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{(OUT_BYTES_W-OUT_W){1'b0}}, r_data};

endmodule

>>> sv/q24_8_fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu
// Signed Q24.8 arithmetic unit, fully pipelined.
// Stages: front, multiply, 40 single-bit divide steps, output register.
// Throughput: one word per cycle; the whole pipe holds while the output
// word waits. Reset clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module q24_8_fixed_point_alu (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // operation[3:0], operand_a[35:4], operand_b[67:36], zero fill
    input  logic [q24a_pkg::IN_BYTES_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // result_value[31:0], a_less, a_equal, a_greater, overflowed,
    // divided_by_zero, zero fill
    output logic [q24a_pkg::OUT_BYTES_W-1:0]     m_axis_tdata
);
    import q24a_pkg::*;

    logic   en;
    logic   v [DIV_STEPS+2];
    t_stage st [DIV_STEPS+2];

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    q24a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tdata[3:0]),
        .i_a     (s_axis_tdata[DATA_WIDTH+3:4]),
        .i_b     (s_axis_tdata[2*DATA_WIDTH+3:DATA_WIDTH+4]),
        .o_valid (v[0]),
        .o_stage (st[0])
    );

    q24a_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v[0]),
        .i_stage (st[0]),
        .o_valid (v[1]),
        .o_stage (st[1])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        q24a_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g+1]),
            .i_stage (st[g+1]),
            .o_valid (v[g+2]),
            .o_stage (st[g+2])
        );
    end

    q24a_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v[DIV_STEPS+1]),
        .i_stage (st[DIV_STEPS+1]),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot(m_axis_tdata[DATA_WIDTH+2:DATA_WIDTH]))
        else $error("compare flags not one-hot");

    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[DATA_WIDTH+3] && m_axis_tdata[DATA_WIDTH+4]))
        else $error("overflow and divide by zero together");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[DATA_WIDTH+3] || m_axis_tdata[DATA_WIDTH+4]))
        |-> (m_axis_tdata[DATA_WIDTH-1:0] == MAXV || m_axis_tdata[DATA_WIDTH-1:0] == MINV))
        else $error("saturated word not at a limit");

endmodule

>>> dv/tb_q24_8_fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q24_8_fixed_point_alu
// Self-checking bench for the Q24.8 arithmetic unit. Words are sent on the
// input stream with random gaps. Each result word is compared field by field
// with a prediction computed in the bench from exact wide integer arithmetic.
// ----------------------------------------------------------------------------
module tb_q24_8_fixed_point_alu;
    import q24a_pkg::*;

    typedef struct packed {
        logic        dz;
        logic        ovf;
        logic        gt;
        logic        eq;
        logic        lt;
        logic [31:0] res;
    } t_alu_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_BYTES_W-1:0] s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;

    t_alu_out expected_q[$];
    int       n_errors;
    int       n_checked;
    int       n_sent;
    bit       stall_on;

    q24_8_fixed_point_alu u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sat32(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return MAXV;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return MINV;
        end
        return v[31:0];
    endfunction

    // exact result of one operation, rounding half away from zero
    function automatic t_alu_out alu_predict(input logic [3:0] op,
                                             input logic [31:0] a_raw,
                                             input logic [31:0] b_raw);
        t_alu_out r;
        logic signed [127:0] a, b, v, ma, mb, q, rm;
        logic ovf;
        logic neg;
        a = signed'(a_raw);
        b = signed'(b_raw);
        ovf = 1'b0;
        r = '0;
        r.lt = a < b;
        r.eq = a == b;
        r.gt = a > b;
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        case (op)
            OP_ADD: r.res = sat32(a + b, ovf);
            OP_SUB: r.res = sat32(a - b, ovf);
            OP_MUL: begin
                q = (ma * mb + 128'sd128) >>> 8;
                r.res = sat32(neg ? -q : q, ovf);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                    r.res = a < 0 ? MINV : MAXV;
                end else begin
                    q = (ma <<< 8) / mb;
                    rm = (ma <<< 8) % mb;
                    if (2 * rm >= mb) q = q + 1;
                    r.res = sat32(neg ? -q : q, ovf);
                end
            end
            OP_MIN: r.res = a < b ? a_raw : b_raw;
            OP_MAX: r.res = a > b ? a_raw : b_raw;
            OP_INC: r.res = sat32(a + 1, ovf);
            OP_DEC: r.res = sat32(a - 1, ovf);
            OP_FROM_INT: r.res = sat32(a * 256, ovf);
            OP_TO_INT: begin
                v = a >>> 8;
                r.res = v[31:0];
            end
            default: r.res = '0;
        endcase
        r.ovf = ovf;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h (word %0d)", what, got, want, n_checked);
        n_errors++;
    endtask

    task automatic send_word(input logic [3:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_BYTES_W - IN_W){1'b0}}, b, a, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(alu_predict(op, a, b));
        n_sent++;
    endtask

    // output stall and check
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = stall_on ? $urandom_range(0, 18) : 0;
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            begin
                t_alu_out got, want;
                got = m_axis_tdata[OUT_W-1:0];
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word", got.res, 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.res !== want.res) report_mismatch("result", got.res, want.res);
                    if (got.lt !== want.lt) report_mismatch("a_less", got.lt, want.lt);
                    if (got.eq !== want.eq) report_mismatch("a_equal", got.eq, want.eq);
                    if (got.gt !== want.gt) report_mismatch("a_greater", got.gt, want.gt);
                    if (got.ovf !== want.ovf) report_mismatch("overflowed", got.ovf, want.ovf);
                    if (got.dz !== want.dz) report_mismatch("div_by_zero", got.dz, want.dz);
                end
                n_checked++;
            end
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return MAXV - $urandom_range(0, 3);
            1: return MINV + $urandom_range(0, 3);
            2: return $urandom_range(0, 1023) - 512;
            3: return ($urandom_range(0, 65535) - 32768) << $urandom_range(0, 8);
            4: return $urandom_range(0, 2) == 0 ? 32'd0 : 32'd256;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_edges();
        logic [31:0] vals [6];
        vals = '{MAXV, MINV, 32'd0, 32'hFFFF_FFFF, 32'd256, 32'h0000_0080};
        for (int op = 0; op < 10; op++)
            send_word(4'(op), vals[op % 6], vals[(op + 2) % 6]);
        send_word(OP_DIV, 32'd0, 32'd0);
        send_word(OP_DIV, MINV, 32'd0);
        send_word(OP_DIV, MINV, 32'hFFFF_FFFF);
        send_word(OP_MUL, MINV, MINV);
        send_word(OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
        send_word(OP_FROM_INT, 32'h007F_FFFF, 32'd0);
        send_word(OP_FROM_INT, 32'h0080_0000, 32'd0);
        send_word(OP_FROM_INT, 32'hFF80_0000, 32'd0);
        send_word(OP_TO_INT, 32'hFFFF_FFFF, MAXV);
        send_word(4'd10, 32'd5, 32'd5);
        send_word(4'd15, MAXV, MINV);
        send_word(OP_INC, MAXV, 32'd0);
        send_word(OP_DEC, MINV, 32'd0);
    endtask

    task automatic test_drain_pause();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_random(input int count);
        logic [3:0] op;
        for (int i = 0; i < count; i++) begin
            op = $urandom_range(0, 19) == 0 ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            send_word(op, pick_operand(), $urandom_range(0, 15) == 0 ? 32'd0 : pick_operand());
        end
    endtask

    task automatic test_back_to_back(input int count);
        stall_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {{(IN_BYTES_W - IN_W){1'b0}}, $urandom(), $urandom(), 4'(i % 10)};
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            expected_q.push_back(alu_predict(s_axis_tdata[3:0], s_axis_tdata[35:4],
                                             s_axis_tdata[67:36]));
            n_sent++;
        end
        stall_on = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        stall_on      = 1'b1;
        n_errors      = 0;
        n_checked     = 0;
        n_sent        = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges();
        test_drain_pause();
        test_random(700);
        test_back_to_back(100);
        test_drain_pause();
        test_random(630);
        test_drain_pause();
        repeat (60) @(posedge i_clk);
        $display("sent %0d words, checked %0d results across all ten operations,", n_sent,
                 n_checked);
        $display("saturation, divide by zero, unknown codes and random stalls");
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("q24_8_fixed_point_alu regression: pass");
        end else begin
            $display("q24_8_fixed_point_alu regression: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout");
        $display("q24_8_fixed_point_alu regression: fail");
        $finish;
    end

endmodule
